### hdl/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants
// Command codes, controller states and the command/status structs that join
// the controller and the datapath of the point-in-polygon block.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_WIDTH_DEF  = 24;

  localparam int IDX_W       = 6;   // vertex_index field
  localparam int CFG_W       = 7;   // vertex_count register
  localparam int CNT_W       = 7;   // crossing_count field
  localparam int OUT_TDATA_W = 8;   // inside_res + crossing_count

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } pip_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } pip_state_t;

  typedef struct packed {
    logic clear;     // start of a query: latch the point, clear the count
    logic wr_en;     // vertex load
    logic rd_en;     // read one vertex from the store
    logic edge_en;   // the vertex read closes an edge with the previous one
    logic load_out;  // move the finished count into the output register
  } pip_cmd_t;

  typedef struct packed {
    logic busy;      // edge pipeline still holds work
    logic out_free;  // output register can take a result this cycle
  } pip_sts_t;

endpackage

### hdl/pip_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_ctrl: query sequencer
// Holds the vertex_count register, takes input transfers and walks the
// vertex store one address per cycle during a query.
// ----------------------------------------------------------------------------
module pip_ctrl #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int AW           = $clog2(MAX_VERTICES),
  parameter int NW           = $clog2(MAX_VERTICES + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic                      in_op,
  input  logic                      cfg_we,
  input  logic [pip_pkg::CFG_W-1:0] cfg_wdata,
  input  pip_pkg::pip_sts_t         sts,
  output pip_pkg::pip_cmd_t         cmd,
  output logic [AW-1:0]             rd_addr
);
  import pip_pkg::*;

  pip_state_t       state_r, state_nxt;
  logic [CFG_W-1:0] vcount_r;
  logic [NW-1:0]    k_r, k_nxt;
  logic [NW-1:0]    n_sat;

  always_comb begin
    if (32'(vcount_r) > MAX_VERTICES) begin
      n_sat = NW'(MAX_VERTICES);
    end else begin
      n_sat = NW'(vcount_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      vcount_r <= '0;
      k_r      <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      if (cfg_we) begin
        vcount_r <= cfg_wdata;
      end
    end
  end

  // Reads go 0, 1, ..., n-1 and then 0 again so that the last read closes
  // the polygon; the first read only primes the previous-vertex register.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cmd       = '0;
    rd_addr   = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_op == CMD_LOAD) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.clear = 1'b1;
            k_nxt     = '0;
            state_nxt = (n_sat == '0) ? ST_FINISH : ST_WALK;
          end
        end
      end
      ST_WALK: begin
        cmd.rd_en   = 1'b1;
        cmd.edge_en = (k_r != '0);
        rd_addr     = (k_r == n_sat) ? '0 : k_r[AW-1:0];
        k_nxt       = k_r + NW'(1);
        if (k_r == n_sat) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### hdl/pip_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_datapath: vertex store and edge pipeline
// Stores the polygon, tests each edge against the query point with an exact
// cross-multiplication compare, counts crossings and holds the result.
// ----------------------------------------------------------------------------
module pip_datapath #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF,
  parameter int AW           = $clog2(MAX_VERTICES)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pip_pkg::pip_cmd_t               cmd,
  input  logic [AW-1:0]                   rd_addr,
  input  logic [pip_pkg::IDX_W-1:0]       vertex_index,
  input  logic signed [COORD_WIDTH-1:0]   coord_x,
  input  logic signed [COORD_WIDTH-1:0]   coord_y,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [pip_pkg::OUT_TDATA_W-1:0] out_tdata,
  output pip_pkg::pip_sts_t               sts
);
  import pip_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int XW = (AW > IDX_W) ? AW : IDX_W;

  logic signed [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];

  logic [XW-1:0] idx_ext;
  logic          slot_ok;

  logic signed [COORD_WIDTH-1:0] px_r, py_r;
  logic signed [COORD_WIDTH-1:0] rd_x_r, rd_y_r;
  logic signed [COORD_WIDTH-1:0] prev_x_r, prev_y_r;
  logic                          rdv_r, rde_r;

  logic                          straddle;
  logic signed [DW-1:0]          dxp_nxt, dy_nxt, dyq_nxt, dx_nxt;
  logic signed [DW-1:0]          s1_dxp_r, s1_dy_r, s1_dyq_r, s1_dx_r;
  logic                          s1_v_r;

  logic signed [PW-1:0]          lhs_r, rhs_r;
  logic                          s2_v_r, s2_neg_r;
  logic                          hit;

  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              out_cnt_r;
  logic                          out_valid_r;

  assign idx_ext = XW'(vertex_index);
  assign slot_ok = (32'(vertex_index) < MAX_VERTICES);

  // Vertex store: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en && slot_ok) begin
      mem_x[idx_ext[AW-1:0]] <= coord_x;
      mem_y[idx_ext[AW-1:0]] <= coord_y;
    end
    if (cmd.rd_en) begin
      rd_x_r <= mem_x[rd_addr];
      rd_y_r <= mem_y[rd_addr];
    end
  end

  // Edge from the previous vertex (x1, y1) to the vertex just read (x2, y2).
  always_comb begin
    straddle = ((prev_y_r <= py_r) && (rd_y_r > py_r)) ||
               ((prev_y_r > py_r) && (rd_y_r <= py_r));
    dxp_nxt  = DW'(px_r)   - DW'(prev_x_r);
    dy_nxt   = DW'(rd_y_r) - DW'(prev_y_r);
    dyq_nxt  = DW'(py_r)   - DW'(prev_y_r);
    dx_nxt   = DW'(rd_x_r) - DW'(prev_x_r);
  end

  // The crossing lies right of the point when (px-x1)*dy and (py-y1)*dx
  // compare in the direction given by the sign of dy.
  assign hit = s2_v_r && ((!s2_neg_r && (lhs_r < rhs_r)) ||
                          (s2_neg_r && (lhs_r > rhs_r)));

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      px_r <= coord_x;
      py_r <= coord_y;
    end
    if (rdv_r) begin
      prev_x_r <= rd_x_r;
      prev_y_r <= rd_y_r;
    end
    s1_dxp_r <= dxp_nxt;
    s1_dy_r  <= dy_nxt;
    s1_dyq_r <= dyq_nxt;
    s1_dx_r  <= dx_nxt;
    lhs_r    <= s1_dxp_r * s1_dy_r;
    rhs_r    <= s1_dyq_r * s1_dx_r;
    s2_neg_r <= s1_dy_r[DW-1];
    if (cmd.load_out) begin
      out_cnt_r <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r       <= 1'b0;
      rde_r       <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rdv_r  <= cmd.rd_en;
      rde_r  <= cmd.edge_en;
      s1_v_r <= rdv_r && rde_r && straddle;
      s2_v_r <= s1_v_r;
      if (cmd.clear) begin
        count_r <= '0;
      end else if (hit) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.busy     = rdv_r || s1_v_r || s2_v_r;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_cnt_r[0]};

endmodule

### hdl/point_in_polygon_crossing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_crossing: even-odd ray-crossing test
// Input transfers either load one polygon vertex or query a point. A query
// returns one result: the parity (inside flag) and the edge crossing count.
//
// Write vertex_count on cfg_we/cfg_wdata while no query is in progress.
// A load transfer produces no result. A query walks the vertex store one read
// per cycle: with n = min(vertex_count, MAX_VERTICES) it takes n + 1 store
// reads, then drains the edge pipeline (edge setup, multiply, compare), enters
// the output state and loads the output register, which raises out_tvalid.
// The next item is taken only once the sequencer is back in idle, so a query
// is never overlapped with the next item. An empty polygon goes straight to
// the output state. A result waits in the output register while the next
// load or query is taken; a query that finishes while the previous result is
// still stalled waits for out_tready before it is delivered, and holds off the
// input meanwhile.
// Reset clears vertex_count, the sequencer and the output register; the
// vertex store is not cleared and must be loaded before it is queried.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF,
  parameter int IN_TDATA_W   = ((pip_pkg::IDX_W + 2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // vertex_index, coord_x, coord_y, zero fill
  input  logic [IN_TDATA_W-1:0]           in_tdata,
  // command
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // inside_res, crossing_count
  output logic [pip_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [pip_pkg::CFG_W-1:0]       cfg_wdata
);
  import pip_pkg::*;

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int XLO = IDX_W;
  localparam int YLO = IDX_W + COORD_WIDTH;

  pip_cmd_t                      cmd;
  pip_sts_t                      sts;
  logic [AW-1:0]                 rd_addr;
  logic [IDX_W-1:0]              vertex_index;
  logic signed [COORD_WIDTH-1:0] coord_x, coord_y;

  assign vertex_index = in_tdata[IDX_W-1:0];
  assign coord_x      = in_tdata[XLO +: COORD_WIDTH];
  assign coord_y      = in_tdata[YLO +: COORD_WIDTH];

  pip_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .AW           (AW),
    .NW           (NW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  pip_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH),
    .AW           (AW)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .vertex_index (vertex_index),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_tdata    (out_tdata),
    .sts          (sts)
  );

endmodule
